/* rtl/cfr_pkg.sv */
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants of the canvas fill and rotate engine.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int MAX_SIDE_DEF   = 32;
    localparam int COLOR_BITS_DEF = 4;
    localparam int SIDE_RESET     = 24;

    localparam logic [2:0] KIND_WRITE  = 3'd0;
    localparam logic [2:0] KIND_FILL   = 3'd1;
    localparam logic [2:0] KIND_READ   = 3'd2;
    localparam logic [2:0] KIND_LEFT   = 3'd3;
    localparam logic [2:0] KIND_RIGHT  = 3'd4;
    localparam logic [2:0] KIND_UP     = 3'd5;
    localparam logic [2:0] KIND_DOWN   = 3'd6;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

endpackage

/* rtl/cfr_stack.sv */
// ----------------------------------------------------------------------------
// cfr_stack
// Fill stack: one synchronous memory of cell addresses with a depth counter.
// Pop data is registered and arrives in the cycle after the pop request.
// ----------------------------------------------------------------------------
module cfr_stack #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [AW-1:0] push_data,
    input  logic          pop,
    output logic [AW-1:0] pop_data,
    output logic          empty
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW:0]   depth_reg;
    logic [AW:0]   depth_next;

    always_comb
    begin
        depth_next = depth_reg;
        if (pop && depth_reg != '0)
        begin
            depth_next = depth_reg - 1'b1;
        end
        else if (push && depth_reg < (AW+1)'(DEPTH))
        begin
            depth_next = depth_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop && depth_reg < (AW+1)'(DEPTH))
        begin
            mem[depth_reg[AW-1:0]] <= push_data;
        end
        if (pop && depth_reg != '0)
        begin
            pop_data <= mem[depth_next[AW-1:0]];
        end
    end

    assign empty = (depth_reg == '0);

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && depth_reg == '0) |=> depth_reg == '0)
        else $error("stack pop while empty moved depth");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (depth_reg == $past(depth_reg) || depth_reg == $past(depth_reg) + 1'b1
                  || depth_reg + 1'b1 == $past(depth_reg)))
        else $error("stack depth jumped");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= (AW+1)'(DEPTH))
        else $error("stack depth beyond capacity");

endmodule

/* rtl/canvas_fill_and_rotate.sv */
// ----------------------------------------------------------------------------
// canvas_fill_and_rotate
// Command engine over a square canvas: write, read, flood fill, rotation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises in the
// next cycle and the single result appears with done high for one cycle.
// The receiver cannot stall. All cells go through one single-port canvas
// memory with a registered read, so a cycle does one read or one write.
// After reset a clearing pass zeroes the canvas, one memory entry per cycle
// (MAX_SIDE*MAX_SIDE entries for a power-of-two side), with busy high. A
// write stores the color and then reads the cell back for the result, a
// read returns the cell it reads, and an out-of-range or unused command
// returns without touching the canvas. A fill pops each recolored cell,
// waits for the popped address, then reads and maybe writes each of its
// four neighbors. A rotation reads each line into a line buffer, then
// writes it back.
// ----------------------------------------------------------------------------
module canvas_fill_and_rotate #(
    parameter int MAX_SIDE   = cfr_pkg::MAX_SIDE_DEF,
    parameter int COLOR_BITS = cfr_pkg::COLOR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            kind,
    input  logic [4:0]            x_pos,
    input  logic [4:0]            y_pos,
    input  logic [3:0]            new_color,
    input  logic                  cfg_we,
    input  logic [5:0]            cfg_data,
    output logic                  done,
    output logic [3:0]            cell_color,
    output logic                  status
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * CW;
    localparam int CELLS = 1 << AW;
    localparam int SW    = CW + 1;

    // state codes
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;   // read wait for read and write commands
    localparam logic [3:0] S_RESP  = 4'd3;   // present result
    localparam logic [3:0] S_FST   = 4'd4;   // fill: start cell data ready
    localparam logic [3:0] S_FPOP  = 4'd5;   // pop issued
    localparam logic [3:0] S_FNRQ  = 4'd6;   // issue neighbor read
    localparam logic [3:0] S_FNCK  = 4'd7;   // neighbor data ready
    localparam logic [3:0] S_RLRD  = 4'd8;   // rotation: read line
    localparam logic [3:0] S_RLWR  = 4'd9;   // rotation: write line
    localparam logic [3:0] S_FFIN  = 4'd10;  // fill: read back start cell
    localparam logic [3:0] S_WTRD  = 4'd11;  // write then read back

    logic [3:0]            state_reg, state_next;
    logic [5:0]            side_cfg_reg;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [2:0]            kind_reg, kind_next;
    logic [CW-1:0]         x_reg, x_next, y_reg, y_next;
    logic [COLOR_BITS-1:0] newc_reg, newc_next, oldc_reg, oldc_next;
    logic [CW-1:0]         cx_reg, cx_next, cy_reg, cy_next;
    logic [1:0]            dir_reg, dir_next;
    logic [CW-1:0]         a_reg, a_next, i_reg, i_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [CW-1:0]         rd_i_reg, rd_i_next;
    logic [3:0]            res_color_reg, res_color_next;
    logic                  res_status_reg, res_status_next;

    logic [COLOR_BITS-1:0] canvas_mem [CELLS];
    logic [COLOR_BITS-1:0] rdata;
    logic [COLOR_BITS-1:0] line_buf [MAX_SIDE];

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_addr;
    logic [COLOR_BITS-1:0] mem_wdata;
    logic                  line_we;
    logic [CW-1:0]         line_wi;

    logic                  st_push, st_pop, st_empty;
    logic [AW-1:0]         st_push_data, st_pop_data;

    // effective side, clamped to 1..MAX_SIDE, and side minus one
    logic [SW-1:0] side;
    logic [CW-1:0] last;
    always_comb
    begin
        if (side_cfg_reg == 6'd0)
        begin
            side = SW'(1);
        end
        else if (32'(side_cfg_reg) > MAX_SIDE)
        begin
            side = SW'(MAX_SIDE);
        end
        else
        begin
            side = SW'(side_cfg_reg);
        end
        last = CW'(side - 1'b1);
    end

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx, input logic [CW-1:0] cy);
        cell_addr = {cy, cx};
    endfunction

    // neighbor of the popped cell in direction dir_reg, and whether it exists
    logic          nb_ok;
    logic [CW-1:0] nb_x, nb_y;
    always_comb
    begin
        nb_x  = cx_reg;
        nb_y  = cy_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            2'd0:
            begin
                nb_ok = (cx_reg != last);
                nb_x  = cx_reg + 1'b1;
            end
            2'd1:
            begin
                nb_ok = (cx_reg != '0);
                nb_x  = cx_reg - 1'b1;
            end
            2'd2:
            begin
                nb_ok = (cy_reg != last);
                nb_y  = cy_reg + 1'b1;
            end
            default:
            begin
                nb_ok = (cy_reg != '0);
                nb_y  = cy_reg - 1'b1;
            end
        endcase
    end

    // rotation source index for line position i_reg
    logic          rot_fwd;
    logic [CW-1:0] rot_src;
    always_comb
    begin
        rot_fwd = (kind_reg == cfr_pkg::KIND_LEFT) || (kind_reg == cfr_pkg::KIND_UP);
        if (rot_fwd)
        begin
            rot_src = (i_reg == last) ? '0 : i_reg + 1'b1;
        end
        else
        begin
            rot_src = (i_reg == '0) ? last : i_reg - 1'b1;
        end
    end

    logic rot_row;
    assign rot_row = (kind_reg == cfr_pkg::KIND_LEFT) || (kind_reg == cfr_pkg::KIND_RIGHT);

    // zero-extend a canvas color into the 4-bit result field
    function automatic logic [3:0] to_res(input logic [COLOR_BITS-1:0] c);
        logic [7:0] w;
        w = 8'(c);
        to_res = w[3:0];
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        kind_next       = kind_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        newc_next       = newc_reg;
        oldc_next       = oldc_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        dir_next        = dir_reg;
        a_next          = a_reg;
        i_next          = i_reg;
        rd_pend_next    = 1'b0;
        rd_i_next       = rd_i_reg;
        res_color_next  = res_color_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = cell_addr(x_reg, y_reg);
        mem_wdata       = newc_reg;
        st_push         = 1'b0;
        st_pop          = 1'b0;
        st_push_data    = cell_addr(x_reg, y_reg);
        line_we         = 1'b0;
        line_wi         = rd_i_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    // latch the request; coordinates are checked here
                    kind_next       = kind;
                    x_next          = CW'(x_pos);
                    y_next          = CW'(y_pos);
                    newc_next       = COLOR_BITS'(new_color);
                    res_color_next  = '0;
                    res_status_next = cfr_pkg::STATUS_DONE;
                    a_next          = '0;
                    i_next          = '0;
                    if (kind <= cfr_pkg::KIND_READ)
                    begin
                        if (SW'(x_pos) >= side || SW'(y_pos) >= side
                            || 32'(x_pos) >= MAX_SIDE || 32'(y_pos) >= MAX_SIDE)
                        begin
                            res_status_next = cfr_pkg::STATUS_OUTSIDE;
                            state_next      = S_RESP;
                        end
                        else if (kind == cfr_pkg::KIND_WRITE)
                        begin
                            mem_we     = 1'b1;
                            mem_addr   = cell_addr(CW'(x_pos), CW'(y_pos));
                            mem_wdata  = COLOR_BITS'(new_color);
                            state_next = S_WTRD;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_addr   = cell_addr(CW'(x_pos), CW'(y_pos));
                            state_next = (kind == cfr_pkg::KIND_FILL) ? S_FST : S_RD;
                        end
                    end
                    else if (kind <= cfr_pkg::KIND_DOWN)
                    begin
                        state_next = S_RLRD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_WTRD:
            begin
                mem_re     = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                res_color_next = to_res(rdata);
                state_next     = S_RESP;
            end
            S_FST:
            begin
                if (rdata == newc_reg)
                begin
                    res_color_next = to_res(rdata);
                    state_next     = S_RESP;
                end
                else
                begin
                    oldc_next  = rdata;
                    mem_we     = 1'b1;
                    st_push    = 1'b1;
                    state_next = S_FPOP;
                end
            end
            S_FPOP:
            begin
                if (st_empty)
                begin
                    mem_re     = 1'b1;
                    state_next = S_FFIN;
                end
                else
                begin
                    st_pop     = 1'b1;
                    state_next = S_FNRQ;
                    dir_next   = 2'd0;
                    rd_pend_next = 1'b1;
                end
            end
            S_FNRQ:
            begin
                if (rd_pend_reg)
                begin
                    cx_next = st_pop_data[CW-1:0];
                    cy_next = st_pop_data[AW-1:CW];
                end
                else if (nb_ok)
                begin
                    mem_re     = 1'b1;
                    mem_addr   = cell_addr(nb_x, nb_y);
                    state_next = S_FNCK;
                end
                else if (dir_reg == 2'd3)
                begin
                    state_next = S_FPOP;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                end
            end
            S_FNCK:
            begin
                mem_addr     = cell_addr(nb_x, nb_y);
                st_push_data = cell_addr(nb_x, nb_y);
                if (rdata == oldc_reg)
                begin
                    mem_we  = 1'b1;
                    st_push = 1'b1;
                end
                if (dir_reg == 2'd3)
                begin
                    state_next = S_FPOP;
                end
                else
                begin
                    dir_next   = dir_reg + 1'b1;
                    state_next = S_FNRQ;
                end
            end
            S_FFIN:
            begin
                res_color_next = to_res(rdata);
                state_next     = S_RESP;
            end
            S_RLRD:
            begin
                // read one line into the buffer, data lands in the next cycle
                if (rd_pend_reg)
                begin
                    line_we = 1'b1;
                end
                if (!rd_pend_reg || i_reg != '0 || rd_i_reg != last)
                begin
                    mem_re       = 1'b1;
                    mem_addr     = rot_row ? cell_addr(rot_src, a_reg)
                                           : cell_addr(a_reg, rot_src);
                    rd_pend_next = 1'b1;
                    rd_i_next    = i_reg;
                    i_next       = (i_reg == last) ? '0 : i_reg + 1'b1;
                end
                if (rd_pend_reg && rd_i_reg == last)
                begin
                    mem_re       = 1'b0;
                    rd_pend_next = 1'b0;
                    i_next       = '0;
                    state_next   = S_RLWR;
                end
            end
            S_RLWR:
            begin
                mem_we    = 1'b1;
                mem_addr  = rot_row ? cell_addr(i_reg, a_reg) : cell_addr(a_reg, i_reg);
                mem_wdata = line_buf[i_reg];
                if (i_reg == last)
                begin
                    i_next = '0;
                    if (a_reg == last)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        a_next     = a_reg + 1'b1;
                        state_next = S_RLRD;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            side_cfg_reg <= 6'(cfr_pkg::SIDE_RESET);
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            rd_pend_reg <= rd_pend_next;
            if (cfg_we)
            begin
                side_cfg_reg <= cfg_data;
            end
        end
    end

    // datapath registers hold their values without reset
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        newc_reg       <= newc_next;
        oldc_reg       <= oldc_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        dir_reg        <= dir_next;
        a_reg          <= a_next;
        i_reg          <= i_next;
        rd_i_reg       <= rd_i_next;
        res_color_reg  <= res_color_next;
        res_status_reg <= res_status_next;
    end

    // canvas memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            canvas_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata <= canvas_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_buf[line_wi] <= rdata;
        end
    end

    cfr_stack #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (st_push),
        .push_data (st_push_data),
        .pop       (st_pop),
        .pop_data  (st_pop_data),
        .empty     (st_empty)
    );

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_RESP);
    assign cell_color = res_color_reg;
    assign status     = res_status_reg;

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("canvas read and write in one cycle");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result not followed by idle");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cfr_pkg::STATUS_OUTSIDE) |-> cell_color == 4'd0)
        else $error("outside request returned a color");

    a_stack_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> st_empty)
        else $error("fill stack not empty at idle");

endmodule

/* verif/canvas_fill_and_rotate_checker.sv */
// ----------------------------------------------------------------------------
// canvas_fill_and_rotate_checker
// Watches the request and result ports of the canvas engine, keeps its own
// copy of the canvas, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module canvas_fill_and_rotate_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [2:0] kind,
    input  logic [4:0] x_pos,
    input  logic [4:0] y_pos,
    input  logic [3:0] new_color,
    input  logic       cfg_we,
    input  logic [5:0] cfg_data,
    input  logic       done,
    input  logic [3:0] cell_color,
    input  logic       status,
    output int         fail_count,
    output int         pending_count,
    output int         result_count
);

    typedef struct packed {
        logic [3:0] color;
        logic       stat;
    } cell_result_t;

    logic [3:0]   model_canvas [0:1023];
    logic [5:0]   model_side;
    cell_result_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic int eff_side();
        int s;
        s = model_side;
        if (s == 0) s = 1;
        if (s > 32) s = 32;
        return s;
    endfunction

    // Flood the 4-connected region of the start cell's color.
    function automatic void flood_region(int x, int y, int side, logic [3:0] nc);
        int          stack [$];
        logic [3:0]  old;
        int          idx, cx, cy, nx, ny;
        old = model_canvas[y * 32 + x];
        if (old == nc) return;
        model_canvas[y * 32 + x] = nc;
        stack.push_back(y * 32 + x);
        while (stack.size() > 0)
        begin
            idx = stack.pop_back();
            cx = idx % 32;
            cy = idx / 32;
            for (int d = 0; d < 4; d++)
            begin
                nx = cx;
                ny = cy;
                if (d == 0) begin if (cx + 1 >= side) continue; nx = cx + 1; end
                if (d == 1) begin if (cx == 0) continue; nx = cx - 1; end
                if (d == 2) begin if (cy + 1 >= side) continue; ny = cy + 1; end
                if (d == 3) begin if (cy == 0) continue; ny = cy - 1; end
                if (model_canvas[ny * 32 + nx] == old)
                begin
                    model_canvas[ny * 32 + nx] = nc;
                    stack.push_back(ny * 32 + nx);
                end
            end
        end
    endfunction

    // dir: 0 left, 1 right, 2 up, 3 down
    function automatic void shift_region(int dir, int side);
        logic [3:0] line [0:31];
        int         src;
        for (int a = 0; a < side; a++)
        begin
            for (int i = 0; i < side; i++)
            begin
                src = (dir == 0 || dir == 2) ? (i + 1) % side : (i + side - 1) % side;
                line[i] = (dir < 2) ? model_canvas[a * 32 + src] : model_canvas[src * 32 + a];
            end
            for (int i = 0; i < side; i++)
                if (dir < 2) model_canvas[a * 32 + i] = line[i];
                else         model_canvas[i * 32 + a] = line[i];
        end
    endfunction

    function automatic cell_result_t predict_command(logic [2:0] k, int x, int y,
                                                     logic [3:0] nc);
        cell_result_t r;
        int           side;
        r = '0;
        side = eff_side();
        if (k == cfr_pkg::KIND_WRITE || k == cfr_pkg::KIND_FILL || k == cfr_pkg::KIND_READ)
        begin
            if (x >= side || y >= side)
                r.stat = cfr_pkg::STATUS_OUTSIDE;
            else
            begin
                if (k == cfr_pkg::KIND_WRITE) model_canvas[y * 32 + x] = nc;
                else if (k == cfr_pkg::KIND_FILL) flood_region(x, y, side, nc);
                r.color = model_canvas[y * 32 + x];
            end
        end
        else if (k == cfr_pkg::KIND_LEFT)  shift_region(0, side);
        else if (k == cfr_pkg::KIND_RIGHT) shift_region(1, side);
        else if (k == cfr_pkg::KIND_UP)    shift_region(2, side);
        else if (k == cfr_pkg::KIND_DOWN)  shift_region(3, side);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t got;
        cell_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 1024; i++) model_canvas[i] = '0;
            model_side = cfr_pkg::SIDE_RESET;
            expected_results.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            // Results first: a request taken this edge cannot finish on it.
            if (done)
            begin
                got.color = cell_color;
                got.stat  = status;
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result color=%0d status=%0d", cell_color, status);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.color !== want.color)
                    begin
                        $error("cell_color expected %0d actual %0d", want.color, got.color);
                        fail_count++;
                    end
                    if (got.stat !== want.stat)
                    begin
                        $error("status expected %0d actual %0d", want.stat, got.stat);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_command(kind, x_pos, y_pos, new_color));
            if (cfg_we)
                model_side = cfg_data;
        end
    end

endmodule

/* verif/tb_canvas_fill_and_rotate.sv */
// ----------------------------------------------------------------------------
// tb_canvas_fill_and_rotate
// Drives commands and side settings into the canvas engine under several
// idle patterns; the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_canvas_fill_and_rotate;

    localparam int CYCLE_LIMIT = 12000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [2:0] kind = cfr_pkg::KIND_READ;
    logic [4:0] x_pos = '0;
    logic [4:0] y_pos = '0;
    logic [3:0] new_color = '0;
    logic       cfg_we = 1'b0;
    logic [5:0] cfg_data = '0;
    logic       done;
    logic [3:0] cell_color;
    logic       status;
    int         fail_count, pending_count, result_count;
    int         cycle_count = 0;
    int         idle_pct = 0;
    int         request_count = 0;
    int         cur_side = cfr_pkg::SIDE_RESET;

    always #4 clk = ~clk;

    canvas_fill_and_rotate u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .x_pos(x_pos), .y_pos(y_pos), .new_color(new_color), .cfg_we(cfg_we),
        .cfg_data(cfg_data), .done(done), .cell_color(cell_color), .status(status)
    );

    canvas_fill_and_rotate_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .x_pos(x_pos), .y_pos(y_pos), .new_color(new_color), .cfg_we(cfg_we),
        .cfg_data(cfg_data), .done(done), .cell_color(cell_color), .status(status),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // Watchdog: covers the clearing pass plus worst-case fills and rotations.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("canvas_fill_and_rotate: mismatch");
            $finish;
        end
    end

    // Send one request: hold start until the engine takes it. Drop start
    // only when a gap comes before the next request.
    task automatic send_request(logic [2:0] k, logic [4:0] x, logic [4:0] y,
                                logic [3:0] c);
        // Insert a random gap before the request.
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start     <= 1'b1;
        kind      <= k;
        x_pos     <= x;
        y_pos     <= y;
        new_color <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        request_count++;
    endtask

    // Drop start, wait for all results, then write the side register while idle.
    task automatic set_side(logic [5:0] s);
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_side = (s == 0) ? 1 : (s > 32 ? 32 : s);
    endtask

    // Random command; most target cells inside the active side.
    task automatic random_request();
        int         r;
        logic [2:0] k;
        logic [4:0] x, y;
        r = $urandom_range(99);
        if (r < 30)      k = cfr_pkg::KIND_WRITE;
        else if (r < 50) k = cfr_pkg::KIND_FILL;
        else if (r < 75) k = cfr_pkg::KIND_READ;
        else if (r < 98) k = 3'($urandom_range(cfr_pkg::KIND_DOWN, cfr_pkg::KIND_LEFT));
        else             k = cfr_pkg::KIND_UNUSED;
        if ($urandom_range(9) == 0)
        begin
            x = 5'($urandom);
            y = 5'($urandom);
        end
        else
        begin
            x = 5'($urandom_range(cur_side - 1));
            y = 5'($urandom_range(cur_side - 1));
        end
        // Few colors so fills find large regions.
        send_request(k, x, y, ($urandom_range(2) == 0) ? 4'($urandom) : 4'($urandom_range(2)));
    endtask

    initial
    begin
        int phase_idle [4] = '{0, 57, 0, 27};
        logic [5:0] phase_side [4] = '{6'd8, 6'd32, 6'd1, 6'd5};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every command, out-of-range and equal-color fill.
        send_request(cfr_pkg::KIND_READ, 5'd0, 5'd0, 4'd0);
        send_request(cfr_pkg::KIND_WRITE, 5'd23, 5'd23, 4'd15);
        send_request(cfr_pkg::KIND_WRITE, 5'd24, 5'd3, 4'd9);
        send_request(cfr_pkg::KIND_READ, 5'd31, 5'd31, 4'd0);
        send_request(cfr_pkg::KIND_FILL, 5'd0, 5'd0, 4'd0);
        send_request(cfr_pkg::KIND_FILL, 5'd0, 5'd0, 4'd10);
        send_request(cfr_pkg::KIND_WRITE, 5'd0, 5'd0, 4'd5);
        send_request(cfr_pkg::KIND_LEFT, 5'd31, 5'd31, 4'd15);
        send_request(cfr_pkg::KIND_RIGHT, 5'd0, 5'd0, 4'd0);
        send_request(cfr_pkg::KIND_UP, 5'd1, 5'd2, 4'd3);
        send_request(cfr_pkg::KIND_DOWN, 5'd2, 5'd1, 4'd4);
        send_request(cfr_pkg::KIND_UNUSED, 5'd31, 5'd0, 4'd15);
        send_request(cfr_pkg::KIND_READ, 5'd0, 5'd0, 4'd0);
        set_side(6'd0);
        send_request(cfr_pkg::KIND_FILL, 5'd0, 5'd0, 4'd7);
        send_request(cfr_pkg::KIND_READ, 5'd1, 5'd0, 4'd0);
        send_request(cfr_pkg::KIND_LEFT, 5'd0, 5'd0, 4'd0);
        set_side(6'd63);
        send_request(cfr_pkg::KIND_WRITE, 5'd31, 5'd31, 4'd1);
        send_request(cfr_pkg::KIND_FILL, 5'd16, 5'd16, 4'd2);
        send_request(cfr_pkg::KIND_READ, 5'd31, 5'd31, 4'd0);
        send_request(cfr_pkg::KIND_DOWN, 5'd0, 5'd0, 4'd0);
        send_request(cfr_pkg::KIND_READ, 5'd31, 5'd0, 4'd0);

        // Random phases with different sides and idle rates; large sides
        // only in one phase since rotations there are slow.
        for (int p = 0; p < 4; p++)
        begin
            set_side(phase_side[p]);
            idle_pct = phase_idle[p];
            for (int i = 0; i < ((phase_side[p] == 32) ? 40 : 75); i++)
                random_request();
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d commands (write, fill, read, four rotations, unused kind)",
                 request_count);
        $display("over sides 1 to 32 with and without idle gaps; %0d results checked",
                 result_count);
        if (fail_count == 0)
            $display("canvas_fill_and_rotate: match");
        else
            $display("canvas_fill_and_rotate: mismatch");
        $finish;
    end

endmodule
